[hw/rtl/m4i_pkg.sv]
package m4i_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T0,
    ST_T1,
    ST_M1,
    ST_M2,
    ST_D1,
    ST_DM,
    ST_OSET,
    ST_DIV,
    ST_RND,
    ST_EMIT
  } back_state_e;

  localparam logic [2:0] LAST_TERM = 3'd5;
  localparam logic [2:0] FIRST_NEG_TERM = 3'd3;

  function automatic logic [1:0] perm_col(input logic [2:0] term, input logic [1:0] pos);
    logic [5:0] p;
    case (term)
      3'd0:    p = {2'd2, 2'd1, 2'd0};
      3'd1:    p = {2'd0, 2'd2, 2'd1};
      3'd2:    p = {2'd1, 2'd0, 2'd2};
      3'd3:    p = {2'd1, 2'd2, 2'd0};
      3'd4:    p = {2'd0, 2'd1, 2'd2};
      3'd5:    p = {2'd2, 2'd0, 2'd1};
      default: p = {2'd2, 2'd1, 2'd0};
    endcase
    case (pos)
      2'd0:    perm_col = p[1:0];
      2'd1:    perm_col = p[3:2];
      default: perm_col = p[5:4];
    endcase
  endfunction

  function automatic logic [1:0] skip_sel(input logic [1:0] skip, input logic [1:0] pos);
    skip_sel = (pos < skip) ? pos : pos + 2'd1;
  endfunction

endpackage

[hw/rtl/m4i_fifo.sv]
module m4i_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (do_pop) begin
      rp_d = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= wdata_i;
    end
  end
endmodule

[hw/rtl/m4i_front.sv]
module m4i_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [DATA_WIDTH-1:0]    element_value_i,
  output logic                     full_o,
  output logic                     mq_push_o,
  output logic [16*DATA_WIDTH-1:0] mq_data_o,
  input  logic                     mq_full_i
);
  localparam int DW = DATA_WIDTH;

  logic [3:0]       cnt_q, cnt_d;
  logic [15*DW-1:0] sh_q, sh_d;
  logic             take;

  assign full_o    = mq_full_i;
  assign take      = push_i && !mq_full_i;
  assign mq_push_o = take && (cnt_q == 4'd15);
  assign mq_data_o = {element_value_i, sh_q};

  always_comb begin
    cnt_d = cnt_q;
    sh_d  = sh_q;
    if (take) begin
      cnt_d = cnt_q + 4'd1;
      sh_d  = {element_value_i, sh_q[15*DW-1:DW]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end
endmodule

[hw/rtl/m4i_back.sv]
module m4i_back #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     mq_empty_i,
  input  logic [16*DATA_WIDTH-1:0] mq_data_i,
  output logic                     mq_pop_o,
  input  logic                     rq_full_i,
  output logic                     rq_push_o,
  output logic [DATA_WIDTH+2:0]    rq_data_o
);
  localparam int DW  = DATA_WIDTH;
  localparam int PW  = 4 * DW + 6;
  localparam int NW  = PW + 2 * FRAC_BITS;
  localparam int CW  = $clog2(NW + 1);
  localparam int MW  = $clog2(DW);
  localparam bit ONE_SAT = (FRAC_BITS >= DW - 1);
  localparam logic [DW-1:0] ONE_V = ONE_SAT ? {1'b0, {(DW-1){1'b1}}} : (DW'(1) << FRAC_BITS);
  localparam logic [DW:0] LIM_POS = (DW+1)'((DW+1)'(1) << (DW - 1)) - (DW+1)'(1);
  localparam logic [DW:0] LIM_NEG = (DW+1)'(1) << (DW - 1);

  m4i_pkg::back_state_e st_q, st_d;
  logic [3:0]       kc_q, kc_d, ok_q, ok_d;
  logic [2:0]       tp_q, tp_d;
  logic [MW-1:0]    mi_q, mi_d;
  logic [CW-1:0]    dc_q, dc_d;
  logic [16*DW-1:0] m_q, m_d;
  logic [PW-1:0]    cof_q [16];
  logic [PW-1:0]    cacc_q, cacc_d, det_q, det_d, acc_q, acc_d, mc_q, mc_d, d_q, d_d;
  logic [DW-1:0]    mp_q, mp_d, ql_q, ql_d, val_q, val_d;
  logic [NW-1:0]    n_q, n_d;
  logic [PW:0]      rem_q, rem_d;
  logic             hi_q, hi_d, neg_q, neg_d, sing_q, sing_d, sat_q, sat_d;
  logic             cof_we;
  logic [PW-1:0]    cof_wd;
  logic [3:0]       eidx, cidx;
  logic [1:0]       epos;
  logic [DW-1:0]    elem;
  logic [PW-1:0]    elem_x, cof_rd, addend, prod, tsum, cv_abs, det_abs;
  logic [PW+1:0]    r2;
  logic             ge, rb, mlast, diag;
  logic [DW:0]      qr, lim, qv;

  assign epos = (st_q == m4i_pkg::ST_T0) ? 2'd0 : (st_q == m4i_pkg::ST_T1) ? 2'd1 : 2'd2;

  always_comb begin
    case (st_q)
      m4i_pkg::ST_T0, m4i_pkg::ST_T1, m4i_pkg::ST_M1: begin
        eidx = {m4i_pkg::skip_sel(kc_q[3:2], epos),
                m4i_pkg::skip_sel(kc_q[1:0], m4i_pkg::perm_col(tp_q, epos))};
      end
      m4i_pkg::ST_D1: begin
        eidx = kc_q;
      end
      default: begin
        eidx = '0;
      end
    endcase
  end

  assign elem    = m_q[eidx*DW +: DW];
  assign elem_x  = {{(PW-DW){elem[DW-1]}}, elem};
  assign cidx    = (st_q == m4i_pkg::ST_OSET) ? {ok_q[1:0], ok_q[3:2]} : kc_q;
  assign cof_rd  = cof_q[cidx];
  assign mlast   = (mi_q == MW'(DW - 1));
  assign addend  = mp_q[0] ? (mlast ? -mc_q : mc_q) : '0;
  assign prod    = acc_q + addend;
  assign tsum    = (tp_q >= m4i_pkg::FIRST_NEG_TERM) ? cacc_q - prod : cacc_q + prod;
  assign cv_abs  = cof_rd[PW-1] ? -cof_rd : cof_rd;
  assign det_abs = det_q[PW-1] ? -det_q : det_q;
  assign r2      = {rem_q, n_q[NW-1]};
  assign ge      = (r2 >= {1'b0, d_q});
  assign rb      = ({rem_q, 1'b0} >= {2'b0, d_q});
  assign qr      = {1'b0, ql_q} + (DW+1)'(rb);
  assign lim     = neg_q ? LIM_NEG : LIM_POS;
  assign qv      = (hi_q || (qr > lim)) ? lim : qr;
  assign diag    = (ok_q[3:2] == ok_q[1:0]);

  assign rq_data_o = {val_q, sing_q, sat_q, (ok_q == 4'd15)};

  always_comb begin
    st_d = st_q;  kc_d = kc_q;  ok_d = ok_q;  tp_d = tp_q;  mi_d = mi_q;  dc_d = dc_q;
    m_d = m_q;  cacc_d = cacc_q;  det_d = det_q;  acc_d = acc_q;  mc_d = mc_q;  d_d = d_q;
    mp_d = mp_q;  ql_d = ql_q;  val_d = val_q;  n_d = n_q;  rem_d = rem_q;
    hi_d = hi_q;  neg_d = neg_q;  sing_d = sing_q;  sat_d = sat_q;
    cof_we = 1'b0;  cof_wd = tsum;  mq_pop_o = 1'b0;  rq_push_o = 1'b0;
    case (st_q)
      m4i_pkg::ST_IDLE: begin
        if (!mq_empty_i) begin
          mq_pop_o = 1'b1;
          m_d    = mq_data_i;
          kc_d   = '0;
          tp_d   = '0;
          cacc_d = '0;
          det_d  = '0;
          st_d   = m4i_pkg::ST_T0;
        end
      end
      m4i_pkg::ST_T0: begin
        mc_d = elem_x;
        st_d = m4i_pkg::ST_T1;
      end
      m4i_pkg::ST_T1: begin
        mp_d  = elem;
        acc_d = '0;
        mi_d  = '0;
        st_d  = m4i_pkg::ST_M1;
      end
      m4i_pkg::ST_M1, m4i_pkg::ST_M2, m4i_pkg::ST_DM: begin
        acc_d = prod;
        mc_d  = mc_q << 1;
        mp_d  = mp_q >> 1;
        mi_d  = mi_q + 1'b1;
        if (mlast) begin
          mi_d = '0;
          if (st_q == m4i_pkg::ST_M1) begin
            mc_d  = prod;
            mp_d  = elem;
            acc_d = '0;
            st_d  = m4i_pkg::ST_M2;
          end else if (st_q == m4i_pkg::ST_M2) begin
            if (tp_q == m4i_pkg::LAST_TERM) begin
              cof_we = 1'b1;
              cof_wd = (kc_q[2] ^ kc_q[0]) ? -tsum : tsum;
              cacc_d = '0;
              tp_d   = '0;
              kc_d   = kc_q + 4'd1;
              st_d   = (kc_q == 4'd15) ? m4i_pkg::ST_D1 : m4i_pkg::ST_T0;
            end else begin
              cacc_d = tsum;
              tp_d   = tp_q + 3'd1;
              st_d   = m4i_pkg::ST_T0;
            end
          end else begin
            det_d = det_q + prod;
            kc_d  = kc_q + 4'd1;
            ok_d  = '0;
            st_d  = (kc_q == 4'd3) ? m4i_pkg::ST_OSET : m4i_pkg::ST_D1;
          end
        end
      end
      m4i_pkg::ST_D1: begin
        mc_d  = cof_rd;
        mp_d  = elem;
        acc_d = '0;
        mi_d  = '0;
        st_d  = m4i_pkg::ST_DM;
      end
      m4i_pkg::ST_OSET: begin
        if (det_q == '0) begin
          val_d  = diag ? ONE_V : '0;
          sing_d = 1'b1;
          sat_d  = diag && ONE_SAT;
          st_d   = m4i_pkg::ST_EMIT;
        end else begin
          neg_d = cof_rd[PW-1] ^ det_q[PW-1];
          n_d   = {cv_abs, {(2*FRAC_BITS){1'b0}}};
          d_d   = det_abs;
          rem_d = '0;
          ql_d  = '0;
          hi_d  = 1'b0;
          dc_d  = CW'(NW - 1);
          st_d  = m4i_pkg::ST_DIV;
        end
      end
      m4i_pkg::ST_DIV: begin
        rem_d = ge ? (PW+1)'(r2 - {1'b0, d_q}) : r2[PW:0];
        ql_d  = {ql_q[DW-2:0], ge};
        hi_d  = hi_q || (ge && (dc_q >= CW'(DW)));
        n_d   = n_q << 1;
        dc_d  = dc_q - 1'b1;
        if (dc_q == '0) begin
          st_d = m4i_pkg::ST_RND;
        end
      end
      m4i_pkg::ST_RND: begin
        val_d  = neg_q ? -qv[DW-1:0] : qv[DW-1:0];
        sat_d  = hi_q || (qr > lim);
        sing_d = 1'b0;
        st_d   = m4i_pkg::ST_EMIT;
      end
      m4i_pkg::ST_EMIT: begin
        if (!rq_full_i) begin
          rq_push_o = 1'b1;
          ok_d = ok_q + 4'd1;
          st_d = (ok_q == 4'd15) ? m4i_pkg::ST_IDLE : m4i_pkg::ST_OSET;
        end
      end
      default: begin
        st_d = m4i_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= m4i_pkg::ST_IDLE;
      kc_q <= '0;
      ok_q <= '0;
      tp_q <= '0;
      mi_q <= '0;
      dc_q <= '0;
    end else begin
      st_q <= st_d;
      kc_q <= kc_d;
      ok_q <= ok_d;
      tp_q <= tp_d;
      mi_q <= mi_d;
      dc_q <= dc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    cacc_q <= cacc_d;
    det_q  <= det_d;
    acc_q  <= acc_d;
    mc_q   <= mc_d;
    mp_q   <= mp_d;
    d_q    <= d_d;
    n_q    <= n_d;
    rem_q  <= rem_d;
    ql_q   <= ql_d;
    hi_q   <= hi_d;
    neg_q  <= neg_d;
    val_q  <= val_d;
    sing_q <= sing_d;
    sat_q  <= sat_d;
    if (cof_we) begin
      cof_q[kc_q] <= cof_wd;
    end
  end
endmodule

[hw/rtl/matrix4x4_inverse.sv]
// 4x4 matrix inverse, signed fixed point (DATA_WIDTH bits, FRAC_BITS fraction bits).
// Push sixteen elements row-major; after the sixteenth, sixteen results come out
// row-major: adjugate over determinant, rounded to nearest (ties away from zero),
// saturated with a flag; a zero determinant gives the identity with singular set.
// The loader takes one element a cycle while the matrix queue is not full, and
// buffers up to two complete matrices ahead of the engine. The engine uses one
// bit-serial multiplier and one bit-serial divider: 196 serial multiplies and
// 16 restoring divisions of a 4*DATA_WIDTH + 2*FRAC_BITS + 6 bit dividend per
// matrix. A singular matrix skips the divisions.
// A four-deep result queue decouples pop.
module matrix4x4_inverse #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [DATA_WIDTH-1:0] element_value_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [DATA_WIDTH-1:0] inverse_value_o,
  output logic                         singular_o,
  output logic                         saturated_o,
  output logic                         is_last_o
);
  localparam int DW = DATA_WIDTH;

  logic             mq_push, mq_full, mq_pop, mq_empty;
  logic [16*DW-1:0] mq_wdata, mq_rdata;
  logic             rq_push, rq_full;
  logic [DW+2:0]    rq_wdata, rq_rdata;

  m4i_front #(.DATA_WIDTH(DW)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .element_value_i(element_value_i), .full_o(full),
    .mq_push_o(mq_push), .mq_data_o(mq_wdata), .mq_full_i(mq_full)
  );

  m4i_fifo #(.WIDTH(16*DW), .DEPTH(2)) u_mq (
    .clk_i, .rst_ni,
    .push_i(mq_push), .wdata_i(mq_wdata), .full_o(mq_full),
    .pop_i(mq_pop), .rdata_o(mq_rdata), .empty_o(mq_empty)
  );

  m4i_back #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DW)) u_back (
    .clk_i, .rst_ni,
    .mq_empty_i(mq_empty), .mq_data_i(mq_rdata), .mq_pop_o(mq_pop),
    .rq_full_i(rq_full), .rq_push_o(rq_push), .rq_data_o(rq_wdata)
  );

  m4i_fifo #(.WIDTH(DW+3), .DEPTH(4)) u_rq (
    .clk_i, .rst_ni,
    .push_i(rq_push), .wdata_i(rq_wdata), .full_o(rq_full),
    .pop_i(pop), .rdata_o(rq_rdata), .empty_o(empty)
  );

  assign inverse_value_o = rq_rdata[DW+2:3];
  assign singular_o      = rq_rdata[2];
  assign saturated_o     = rq_rdata[1];
  assign is_last_o       = rq_rdata[0];
endmodule

[hw/rtl/m4i_checker.sv]
module m4i_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  push,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input logic [DATA_WIDTH-1:0] inverse_value_o,
  input logic                  singular_o,
  input logic                  is_last_o
);
  logic [3:0] in_cnt_q, out_cnt_q;
  logic [3:0] pend_q, pend_d;
  logic       sing_q;
  logic       in_done, out_done;

  assign in_done  = push && !full && (in_cnt_q == 4'd15);
  assign out_done = pop && !empty && (out_cnt_q == 4'd15);

  always_comb begin
    pend_d = pend_q;
    if (in_done && !out_done) begin
      pend_d = pend_q + 4'd1;
    end else if (out_done && !in_done) begin
      pend_d = pend_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      pend_q    <= '0;
      sing_q    <= 1'b0;
    end else begin
      if (push && !full) begin
        in_cnt_q <= in_cnt_q + 4'd1;
      end
      if (pop && !empty) begin
        out_cnt_q <= out_cnt_q + 4'd1;
        if (out_cnt_q == 4'd0) begin
          sing_q <= singular_o;
        end
      end
      pend_q <= pend_d;
    end
  end

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (is_last_o == (out_cnt_q == 4'd15)))
    else $error("last flag out of place");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pend_q != 4'd0))
    else $error("result without a complete matrix");

  a_sing_const: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_cnt_q != 4'd0)) |-> (singular_o == sing_q))
    else $error("singular flag changed within a matrix");

  a_ident_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && singular_o && (out_cnt_q[3:2] != out_cnt_q[1:0])) |-> (inverse_value_o == '0))
    else $error("identity off-diagonal not zero");
endmodule

bind matrix4x4_inverse m4i_checker #(.DATA_WIDTH(DATA_WIDTH)) u_m4i_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .push(push),
  .full(full),
  .empty(empty),
  .pop(pop),
  .inverse_value_o(inverse_value_o),
  .singular_o(singular_o),
  .is_last_o(is_last_o)
);

[tb/tb_matrix4x4_inverse.sv]
module tb_matrix4x4_inverse;

  localparam int DW = 32;
  localparam int FB = 16;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [DW-1:0] elem_t;

  typedef struct packed {
    logic [DW-1:0] value;
    logic          singular;
    logic          saturated;
    logic          last;
  } inv_res_t;

  typedef struct {
    elem_t mtx[16];
    bit    typed;
    bit    sing;
  } dir_row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          push;
  logic          full;
  elem_t         element_value_i;
  logic          empty;
  logic          pop;
  elem_t         inverse_value_o;
  logic          singular_o;
  logic          saturated_o;
  logic          is_last_o;

  inv_res_t      inverse_q[$];
  int            mismatches;
  int            pop_stall;

  matrix4x4_inverse #(.FRAC_BITS(FB), .DATA_WIDTH(DW)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .element_value_i(element_value_i),
    .empty(empty), .pop(pop),
    .inverse_value_o(inverse_value_o), .singular_o(singular_o),
    .saturated_o(saturated_o), .is_last_o(is_last_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic wide_t minor_det(input elem_t m[16], input int r, input int c);
    wide_t mm[9];
    wide_t t;
    int n;
    n = 0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (i != r && j != c) begin
          mm[n] = m[i*4+j];
          n++;
        end
      end
    end
    t = mm[0] * (mm[4] * mm[8] - mm[5] * mm[7])
      - mm[1] * (mm[3] * mm[8] - mm[5] * mm[6])
      + mm[2] * (mm[3] * mm[7] - mm[4] * mm[6]);
    return ((r + c) % 2 == 1) ? -t : t;
  endfunction

  task automatic predict_inverse(input elem_t m[16]);
    wide_t cof[16];
    wide_t det, num, an, ad, q, rem, lim;
    inv_res_t res;
    bit neg;
    det = '0;
    for (int k = 0; k < 16; k++) cof[k] = minor_det(m, k / 4, k % 4);
    for (int k = 0; k < 4; k++) det = det + wide_t'(m[k]) * cof[k];
    for (int k = 0; k < 16; k++) begin
      res = '0;
      res.last = (k == 15);
      if (det == 0) begin
        res.singular = 1'b1;
        res.value = (k / 4 == k % 4) ? DW'(1) << FB : '0;
      end else begin
        num = cof[(k % 4) * 4 + k / 4] <<< (2 * FB);
        neg = (num < 0) != (det < 0);
        an = (num < 0) ? -num : num;
        ad = (det < 0) ? -det : det;
        q = an / ad;
        rem = an - q * ad;
        if (2 * rem >= ad) q = q + 1;
        lim = (wide_t'(1) <<< (DW - 1)) - (neg ? 0 : 1);
        if (q > lim) begin
          q = lim;
          res.saturated = 1'b1;
        end
        res.value = neg ? DW'(-q) : DW'(q);
      end
      inverse_q.push_back(res);
    end
  endtask

  task automatic send_matrix(input elem_t m[16]);
    int gap;
    for (int k = 0; k < 16; k++) begin
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 200);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      push <= 1'b1;
      element_value_i <= m[k];
      do @(posedge clk_i); while (full);
    end
  endtask

  function automatic void make_random(output elem_t m[16]);
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 16; k++) begin
      case (kind)
        0, 1, 2: m[k] = $urandom;
        3:       m[k] = (k / 4 == k % 4) ? elem_t'($urandom_range(1, 40)) : '0;
        4:       m[k] = elem_t'(($urandom_range(0, 8) - 4)) <<< FB;
        default: m[k] = elem_t'($urandom_range(0, 2 * 262144) - 262144);
      endcase
    end
    if (kind == 7 || kind == 8) begin
      for (int j = 0; j < 4; j++) m[12 + j] = m[$urandom_range(0, 2) * 4 + j];
    end
  endfunction

  always @(posedge clk_i) begin
    inv_res_t exp_r;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (inverse_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", inverse_value_o);
        end else begin
          exp_r = inverse_q.pop_front();
          if (exp_r.value !== inverse_value_o || exp_r.singular !== singular_o ||
              exp_r.saturated !== saturated_o || exp_r.last !== is_last_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h sing %b sat %b last %b, got %h sing %b sat %b last %b",
                       exp_r.value, exp_r.singular, exp_r.saturated, exp_r.last,
                       inverse_value_o, singular_o, saturated_o, is_last_o);
          end
        end
      end
      if (pop_stall > 0) begin
        pop <= 1'b0;
        pop_stall <= pop_stall - 1;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 9) < 2)
          pop_stall <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(30, 300);
      end
    end
  end

  initial begin
    #20000000;
    $display("** matrix4x4_inverse: FAILED **");
    $finish;
  end

  initial begin
    dir_row_t dir_tbl[3];
    elem_t m[16];
    inv_res_t res;
    push = 1'b0;
    pop = 1'b0;
    element_value_i = '0;
    pop_stall = 0;
    mismatches = 0;
    rst_ni = 1'b0;
    for (int k = 0; k < 16; k++) begin
      dir_tbl[0].mtx[k] = (k / 4 == k % 4) ? elem_t'(1) <<< FB : '0;
      dir_tbl[1].mtx[k] = '0;
      dir_tbl[2].mtx[k] = (k / 4 == k % 4) ? '0 : elem_t'(1);
    end
    dir_tbl[0].typed = 1; dir_tbl[0].sing = 0;
    dir_tbl[1].typed = 1; dir_tbl[1].sing = 1;
    dir_tbl[2].typed = 0; dir_tbl[2].sing = 0;
    dir_tbl[2].mtx[0] = 32'sd1;
    dir_tbl[2].mtx[5] = -32'sd1;
    dir_tbl[2].mtx[10] = 32'sh7fffffff;
    dir_tbl[2].mtx[15] = 32'sh80000000;
    dir_tbl[2].mtx[3] = 32'sh80000000;
    dir_tbl[2].mtx[12] = 32'sh7fffffff;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].typed) begin
        for (int k = 0; k < 16; k++) begin
          res.value = (k / 4 == k % 4) ? 32'h0001_0000 : 32'h0;
          res.singular = dir_tbl[i].sing;
          res.saturated = 1'b0;
          res.last = (k == 15);
          inverse_q.push_back(res);
        end
      end else begin
        predict_inverse(dir_tbl[i].mtx);
      end
      send_matrix(dir_tbl[i].mtx);
    end
    for (int n = 0; n < 27; n++) begin
      make_random(m);
      predict_inverse(m);
      send_matrix(m);
    end
    push <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && inverse_q.size() == 0) begin
      $display("** matrix4x4_inverse: PASSED **");
    end else begin
      $display("** matrix4x4_inverse: FAILED **");
    end
    $finish;
  end

endmodule
